// ===== design/r3crc_pkg.sv =====
// Shared types, constants and the CRC24Q byte update for the RTCM3 frame checker.
// No dependencies; the parser and the top level refer to this package by scoped names.
package r3crc_pkg;

   localparam logic [7:0]  PREAMBLE          = 8'hD3;
   // Low 24 bits of 0x1864CFB; the x^24 term is the bit shifted out.
   localparam logic [23:0] CRC_POLY          = 24'h864CFB;
   localparam logic [10:0] MAX_FRAME_LEN_RST = 11'd1029;
   localparam logic [10:0] FRAME_OVERHEAD    = 11'd6;
   localparam logic [10:0] HEADER_BYTES      = 11'd3;
   localparam logic [31:0] COUNT_MAX         = 32'hFFFF_FFFF;

   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_CRC_ERROR  = 2'd1;
   localparam logic [1:0] STATUS_BAD_LENGTH = 2'd2;
   localparam logic [1:0] STATUS_STRAY      = 2'd3;

   typedef struct packed {
      logic        valid;
      logic [1:0]  status;
      logic [11:0] message_type;
      logic [10:0] frame_length;
      logic [7:0]  stray_byte;
      logic [31:0] good_frame_total;
      logic [31:0] crc_error_total;
   } result_type;

   // One byte of CRC24Q, MSB first, no reflection.
   function automatic logic [23:0] crc24q_byte(input logic [23:0] crc_prev,
                                               input logic [7:0]  data);
      logic [23:0] crc;
      crc = crc_prev ^ {data, 16'h0000};
      for (int k = 0; k < 8; k++) begin
         if (crc[23]) begin
            crc = {crc[22:0], 1'b0} ^ CRC_POLY;
         end else begin
            crc = {crc[22:0], 1'b0};
         end
      end
      return crc;
   endfunction

endpackage

// ===== design/r3crc_req_if.sv =====
// Input channel of the RTCM3 frame checker: one received byte per item.
// No dependencies.
interface r3crc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink (input valid, input data_byte, output ready);
endinterface

// ===== design/r3crc_rsp_if.sv =====
// Result channel of the RTCM3 frame checker.
// No dependencies.
interface r3crc_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [11:0] message_type;
   logic [10:0] frame_length;
   logic [7:0]  stray_byte;
   logic [31:0] good_frame_total;
   logic [31:0] crc_error_total;

   modport source (output valid, output status, output message_type, output frame_length,
                   output stray_byte, output good_frame_total, output crc_error_total,
                   input ready);
   modport sink (input valid, input status, input message_type, input frame_length,
                 input stray_byte, input good_frame_total, input crc_error_total,
                 output ready);
endinterface

// ===== design/r3crc_csr_if.sv =====
// Configuration write channel of the RTCM3 frame checker (maximum frame length).
// No dependencies.
interface r3crc_csr_if;
   logic        valid;
   logic        ready;
   logic [10:0] max_frame_len;

   modport source (output valid, output max_frame_len, input ready);
   modport sink (input valid, input max_frame_len, output ready);
endinterface

// ===== design/r3crc_parser.sv =====
// Frame state, CRC24Q accumulation and result generation for one byte per step.
// Depends on r3crc_pkg.
module r3crc_parser (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  logic [7:0]             data_byte,
   input  logic [10:0]            max_frame_len,
   output r3crc_pkg::result_type  result
);

   localparam logic [2:0] PH_HUNT    = 3'd0;
   localparam logic [2:0] PH_LEN_HI  = 3'd1;
   localparam logic [2:0] PH_LEN_LO  = 3'd2;
   localparam logic [2:0] PH_PAYLOAD = 3'd3;
   localparam logic [2:0] PH_CRC     = 3'd4;

   logic [2:0]  phase_ff, phase_in;
   logic [9:0]  payload_len_ff, payload_len_in;
   logic [10:0] byte_index_ff, byte_index_in;
   logic [23:0] running_crc_ff, running_crc_in;
   logic [23:0] received_crc_ff, received_crc_in;
   logic [11:0] captured_type_ff, captured_type_in;
   logic [31:0] good_count_ff, good_count_in;
   logic [31:0] error_count_ff, error_count_in;

   logic [23:0] crc_next;
   logic [10:0] frame_total;
   logic [10:0] new_total;
   logic [10:0] payload_end;

   // A preamble restarts the CRC from zero, otherwise it continues.
   assign crc_next = r3crc_pkg::crc24q_byte((phase_ff == PH_HUNT) ? 24'h000000 : running_crc_ff,
                                            data_byte);
   assign frame_total = {1'b0, payload_len_ff} + r3crc_pkg::FRAME_OVERHEAD;
   assign new_total   = {1'b0, payload_len_ff[9:8], data_byte} + r3crc_pkg::FRAME_OVERHEAD;
   assign payload_end = {1'b0, payload_len_ff} + r3crc_pkg::HEADER_BYTES;

   always_comb begin
      phase_in         = phase_ff;
      payload_len_in   = payload_len_ff;
      byte_index_in    = byte_index_ff;
      running_crc_in   = running_crc_ff;
      received_crc_in  = received_crc_ff;
      captured_type_in = captured_type_ff;
      good_count_in    = good_count_ff;
      error_count_in   = error_count_ff;
      result           = '0;

      case (phase_ff)
         PH_HUNT: begin
            if (data_byte != r3crc_pkg::PREAMBLE) begin
               result.valid      = 1'b1;
               result.status     = r3crc_pkg::STATUS_STRAY;
               result.stray_byte = data_byte;
            end else begin
               running_crc_in   = crc_next;
               received_crc_in  = '0;
               captured_type_in = '0;
               payload_len_in   = '0;
               byte_index_in    = 11'd1;
               phase_in         = PH_LEN_HI;
            end
         end
         PH_LEN_HI: begin
            running_crc_in = crc_next;
            payload_len_in = {data_byte[1:0], 8'h00};
            byte_index_in  = 11'd2;
            phase_in       = PH_LEN_LO;
         end
         PH_LEN_LO: begin
            running_crc_in = crc_next;
            payload_len_in = {payload_len_ff[9:8], data_byte};
            byte_index_in  = r3crc_pkg::HEADER_BYTES;
            if (new_total > max_frame_len) begin
               phase_in            = PH_HUNT;
               byte_index_in       = '0;
               result.valid        = 1'b1;
               result.status       = r3crc_pkg::STATUS_BAD_LENGTH;
               result.frame_length = new_total;
            end else if ({payload_len_ff[9:8], data_byte} == 10'd0) begin
               phase_in = PH_CRC;
            end else begin
               phase_in = PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            running_crc_in = crc_next;
            if (byte_index_ff == 11'd3) begin
               captured_type_in = {data_byte, 4'h0};
            end else if (byte_index_ff == 11'd4) begin
               captured_type_in = captured_type_ff | {8'h00, data_byte[7:4]};
            end
            byte_index_in = byte_index_ff + 11'd1;
            if (byte_index_in >= payload_end) begin
               phase_in = PH_CRC;
            end
         end
         default: begin
            received_crc_in = {received_crc_ff[15:0], data_byte};
            byte_index_in   = byte_index_ff + 11'd1;
            if (!(byte_index_in < frame_total && phase_ff == PH_CRC)) begin
               phase_in            = PH_HUNT;
               byte_index_in       = '0;
               result.valid        = 1'b1;
               result.frame_length = frame_total;
               result.message_type = (payload_len_ff >= 10'd2) ? captured_type_ff : 12'h000;
               if (received_crc_in == running_crc_ff) begin
                  result.status = r3crc_pkg::STATUS_OK;
                  if (good_count_ff != r3crc_pkg::COUNT_MAX) begin
                     good_count_in = good_count_ff + 32'd1;
                  end
               end else begin
                  result.status = r3crc_pkg::STATUS_CRC_ERROR;
                  if (error_count_ff != r3crc_pkg::COUNT_MAX) begin
                     error_count_in = error_count_ff + 32'd1;
                  end
               end
            end
         end
      endcase

      result.good_frame_total = good_count_in;
      result.crc_error_total  = error_count_in;
      result.valid            = result.valid & step;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_HUNT;
         payload_len_ff   <= '0;
         byte_index_ff    <= '0;
         running_crc_ff   <= '0;
         received_crc_ff  <= '0;
         captured_type_ff <= '0;
         good_count_ff    <= '0;
         error_count_ff   <= '0;
      end else if (step) begin
         phase_ff         <= phase_in;
         payload_len_ff   <= payload_len_in;
         byte_index_ff    <= byte_index_in;
         running_crc_ff   <= running_crc_in;
         received_crc_ff  <= received_crc_in;
         captured_type_ff <= captured_type_in;
         good_count_ff    <= good_count_in;
         error_count_ff   <= error_count_in;
      end
   end

   // A stray byte leaves the parser hunting.
   assert property (@(posedge clock) disable iff (reset)
      step && phase_ff == PH_HUNT && data_byte != r3crc_pkg::PREAMBLE |=> phase_ff == PH_HUNT)
      else $error("parser left hunting on a stray byte");

   // Inside a frame the byte position never passes the frame length.
   assert property (@(posedge clock) disable iff (reset)
      phase_ff != PH_HUNT |-> byte_index_ff <= frame_total)
      else $error("byte index beyond frame length");

   // Saturating counters never move backward.
   assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> good_count_ff >= $past(good_count_ff)
                        && error_count_ff >= $past(error_count_ff))
      else $error("frame counter decreased");

endmodule

// ===== design/rtcm3_frame_crc24q_checker.sv =====
// Top level of the RTCM3 frame checker: input register, parser and result register.
// Depends on r3crc_pkg, r3crc_req_if, r3crc_rsp_if, r3crc_csr_if and r3crc_parser.
//
// Usage:
//   req_chan carries one received byte per item. While hunting, every byte other
//   than the 0xD3 preamble comes back as a stray-byte result. After a preamble the
//   block reads the two length bytes, the payload and the 24-bit CRC24Q, and
//   returns one result per frame: ok or CRC error with the message type, frame
//   length and the saturating good/error frame counters. A header announcing a
//   frame longer than the configured limit gives a bad-length result right away.
//   Bytes inside a frame give no result.
//   csr_chan writes the maximum frame length; it is always ready and should only
//   be written while no item is in flight.
// Timing:
//   An accepted item is held in the input register and goes through the parser once
//   the result register is free or is being emptied. Its result, if any, is
//   registered in the result register and offered on rsp_chan from then on. One item
//   per cycle is sustained while rsp_chan is not stalled; the combinational CRC24Q
//   byte update in the parser sets that rate.
// Reset and stalls:
//   Reset puts the parser in hunting, clears both counters and restores the limit
//   to 1029. When rsp_chan is stalled the pending result holds, one more item
//   waits in the input register, and then req_chan.ready drops.
module rtcm3_frame_crc24q_checker (
   input logic          clock,
   input logic          reset,
   r3crc_req_if.sink    req_chan,
   r3crc_rsp_if.source  rsp_chan,
   r3crc_csr_if.sink    csr_chan
);

   logic        in_valid_ff, in_valid_in;
   logic [7:0]  in_byte_ff;
   logic [10:0] max_len_ff;
   logic        out_valid_ff, out_valid_in;
   r3crc_pkg::result_type out_ff;
   r3crc_pkg::result_type parse_result;
   logic        advance;
   logic        req_fire;

   // The held byte moves through the parser when the result register is free
   // or is being emptied in the same cycle.
   assign advance  = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_fire = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;

   r3crc_parser parser_inst (
      .clock         (clock),
      .reset         (reset),
      .step          (advance),
      .data_byte     (in_byte_ff),
      .max_frame_len (max_len_ff),
      .result        (parse_result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      out_valid_in = out_valid_ff;
      if (advance && parse_result.valid) begin
         out_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         max_len_ff   <= r3crc_pkg::MAX_FRAME_LEN_RST;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (csr_chan.valid) begin
            max_len_ff <= csr_chan.max_frame_len;
         end
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_byte_ff <= req_chan.data_byte;
      end
      if (advance && parse_result.valid) begin
         out_ff <= parse_result;
      end
   end

   assign rsp_chan.valid            = out_valid_ff;
   assign rsp_chan.status           = out_ff.status;
   assign rsp_chan.message_type     = out_ff.message_type;
   assign rsp_chan.frame_length     = out_ff.frame_length;
   assign rsp_chan.stray_byte       = out_ff.stray_byte;
   assign rsp_chan.good_frame_total = out_ff.good_frame_total;
   assign rsp_chan.crc_error_total  = out_ff.crc_error_total;

   // A result that is not taken stays pending.
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_chan.ready |=> out_valid_ff)
      else $error("pending result dropped");

   // A new byte never lands on a held byte that has not moved on.
   assert property (@(posedge clock) disable iff (reset)
      !(req_fire && in_valid_ff && !advance))
      else $error("input register overwritten");

   // The parser is only stepped on a byte that was actually received.
   assert property (@(posedge clock) disable iff (reset)
      advance |-> in_valid_ff)
      else $error("parser stepped without an item");

endmodule
